// ----- rtl/core/depth_shell_sort_assert.svh -----
// Assertion macros shared by the depth shell sort checkers.
`ifndef DEPTH_SHELL_SORT_ASSERT_SVH
`define DEPTH_SHELL_SORT_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define DSS_ASSERT_NOW(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (con)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define DSS_ASSERT_NEXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (con)) \
    else $error(msg);

`endif

// ----- rtl/core/dss_pkg.sv -----
// Shared types, constants and the gap table of the depth shell sort.
package dss_pkg;

  // Tag field width
  localparam int TAG_W = 6;

  // Gap table: h = 3h + 1 from 1; 121 exceeds any supported list length
  localparam int GAP_W     = 7;
  localparam int NUM_GAPS  = 5;
  localparam int GAP_IDX_W = 3;

  // Control of the item store between sequencer and memory
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_cmd_t;

  // Gap value at a table index
  function automatic logic [GAP_W-1:0] gap_at(input logic [GAP_IDX_W-1:0] idx);
    logic [GAP_W-1:0] g;
    case (idx)
      3'd0:    g = 7'd1;
      3'd1:    g = 7'd4;
      3'd2:    g = 7'd13;
      3'd3:    g = 7'd40;
      default: g = 7'd121;
    endcase
    return g;
  endfunction

endpackage

// ----- rtl/core/dss_if.sv -----
// Valid/ready channel interfaces for input items and sorted result items.
interface dss_in_if #(
  parameter int KEY_WIDTH = 32
) ();
  logic                        valid;
  logic                        ready;
  logic signed [KEY_WIDTH-1:0] sort_key;
  logic [dss_pkg::TAG_W-1:0]   item_tag;
  logic                        last_item;

  modport source (output valid, sort_key, item_tag, last_item, input ready);
  modport sink   (input valid, sort_key, item_tag, last_item, output ready);
endinterface

interface dss_out_if #(
  parameter int KEY_WIDTH = 32
) ();
  logic                        valid;
  logic                        ready;
  logic signed [KEY_WIDTH-1:0] sorted_key;
  logic [dss_pkg::TAG_W-1:0]   sorted_tag;
  logic                        last_out;

  modport source (output valid, sorted_key, sorted_tag, last_out, input ready);
  modport sink   (input valid, sorted_key, sorted_tag, last_out, output ready);
endinterface

// ----- rtl/core/dss_store.sv -----
// Single-port-write, single-port-read item store with registered read data.
module dss_store #(
  parameter int DEPTH = 64,
  parameter int DW    = 38
) (
  input  logic                     clk_i,
  input  dss_pkg::mem_cmd_t        cmd_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DW-1:0]            wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DW-1:0]            rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/dss_ctrl.sv -----
// Sequencer: list load, shell sort passes over the store, and sorted emission.
module dss_ctrl #(
  parameter int MAX_ITEMS = 64,
  parameter int KEY_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input items
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [KEY_WIDTH-1:0]              in_key_i,
  input  logic [dss_pkg::TAG_W-1:0]         in_tag_i,
  input  logic                              in_last_i,
  // result items
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [KEY_WIDTH-1:0]              out_key_o,
  output logic [dss_pkg::TAG_W-1:0]         out_tag_o,
  output logic                              out_last_o,
  // store access
  output dss_pkg::mem_cmd_t                 mem_cmd_o,
  output logic [$clog2(MAX_ITEMS)-1:0]      waddr_o,
  output logic [KEY_WIDTH+dss_pkg::TAG_W-1:0] wdata_o,
  output logic [$clog2(MAX_ITEMS)-1:0]      raddr_o,
  input  logic [KEY_WIDTH+dss_pkg::TAG_W-1:0] rdata_i
);

  localparam int IDX_W = $clog2(MAX_ITEMS);
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int DW    = KEY_WIDTH + dss_pkg::TAG_W;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ITEMS);

  typedef enum logic [3:0] {
    ST_LOAD,   // take items into the store
    ST_GAP,    // find the first gap above the count
    ST_RDV,    // start insertion of item i (read it)
    ST_GETV,   // latch item i, read the item one gap below
    ST_CMP,    // compare and shift down by one gap
    ST_PUT,    // drop the held item into its slot
    ST_ERD,    // read item k for emission
    ST_ELD,    // load the output register
    ST_EHOLD   // wait for the receiver
  } state_e;

  state_e                       state_q, state_d;
  logic [CNT_W-1:0]             count_q, count_d;
  logic [dss_pkg::GAP_IDX_W-1:0] gi_q, gi_d;
  logic [CNT_W-1:0]             gap_q, gap_d;
  logic [CNT_W-1:0]             i_q, i_d;
  logic [CNT_W-1:0]             j_q, j_d;
  logic [CNT_W-1:0]             k_q, k_d;
  logic [DW-1:0]                v_q, v_d;
  logic                         out_valid_q, out_valid_d;
  logic [DW-1:0]                out_q, out_d;
  logic                         out_last_q, out_last_d;

  logic [CNT_W-1:0]             i_dn;
  logic [CNT_W-1:0]             j_dn;
  logic [CNT_W-1:0]             j_dn2;
  logic [dss_pkg::GAP_W-1:0]    gap_cur;
  logic [dss_pkg::GAP_W-1:0]    gap_prev;
  logic                         key_lt;

  // Shared compare unit: signed key of the lower item below held key
  assign key_lt = $signed(rdata_i[DW-1:dss_pkg::TAG_W]) < $signed(v_q[DW-1:dss_pkg::TAG_W]);
  assign i_dn     = i_q - gap_q;
  assign j_dn     = j_q - gap_q;
  assign j_dn2    = j_dn - gap_q;
  assign gap_cur  = dss_pkg::gap_at(gi_q);
  assign gap_prev = dss_pkg::gap_at(gi_q - 1'b1);

  // Next-state and datapath control
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    gi_d        = gi_q;
    gap_d       = gap_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    v_d         = v_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    out_last_d  = out_last_q;
    mem_cmd_o   = '0;
    waddr_o     = j_q[IDX_W-1:0];
    wdata_o     = v_q;
    raddr_o     = i_q[IDX_W-1:0];
    in_ready_o  = 1'b0;

    unique case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        waddr_o    = count_q[IDX_W-1:0];
        wdata_o    = {in_key_i, in_tag_i};
        if (in_valid_i) begin
          // items past capacity are dropped
          if (count_q < MAX_CNT) begin
            mem_cmd_o.wr_en = 1'b1;
            count_d         = count_q + 1'b1;
          end
          if (in_last_i) begin
            gi_d    = dss_pkg::GAP_IDX_W'(1);
            state_d = ST_GAP;
          end
        end
      end

      ST_GAP: begin
        if (gap_cur <= dss_pkg::GAP_W'(count_q)) begin
          gi_d = gi_q + 1'b1;
        end else begin
          gi_d    = gi_q - 1'b1;
          gap_d   = CNT_W'(gap_prev);
          i_d     = CNT_W'(gap_prev);
          state_d = ST_RDV;
        end
      end

      ST_RDV: begin
        if (i_q < count_q) begin
          mem_cmd_o.rd_en = 1'b1;
          state_d         = ST_GETV;
        end else if (gi_q == '0) begin
          // pass with gap one done: list sorted
          k_d     = '0;
          state_d = ST_ERD;
        end else begin
          gi_d  = gi_q - 1'b1;
          gap_d = CNT_W'(gap_prev);
          i_d   = CNT_W'(gap_prev);
        end
      end

      ST_GETV: begin
        v_d             = rdata_i;
        j_d             = i_q;
        raddr_o         = i_dn[IDX_W-1:0];
        mem_cmd_o.rd_en = 1'b1;
        state_d         = ST_CMP;
      end

      ST_CMP: begin
        mem_cmd_o.wr_en = 1'b1;
        if (key_lt) begin
          // move the lower item up one gap
          wdata_o = rdata_i;
          j_d     = j_dn;
          if (j_dn < gap_q) begin
            state_d = ST_PUT;
          end else begin
            raddr_o         = j_dn2[IDX_W-1:0];
            mem_cmd_o.rd_en = 1'b1;
          end
        end else begin
          i_d     = i_q + 1'b1;
          state_d = ST_RDV;
        end
      end

      ST_PUT: begin
        mem_cmd_o.wr_en = 1'b1;
        i_d             = i_q + 1'b1;
        state_d         = ST_RDV;
      end

      ST_ERD: begin
        raddr_o         = k_q[IDX_W-1:0];
        mem_cmd_o.rd_en = 1'b1;
        state_d         = ST_ELD;
      end

      ST_ELD: begin
        out_d       = rdata_i;
        out_last_d  = (CNT_W'(k_q + 1'b1) == count_q);
        out_valid_d = 1'b1;
        state_d     = ST_EHOLD;
      end

      ST_EHOLD: begin
        if (out_ready_i) begin
          out_valid_d = 1'b0;
          if (out_last_q) begin
            count_d = '0;
            state_d = ST_LOAD;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = ST_ERD;
          end
        end
      end

      default: state_d = ST_LOAD;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      count_q     <= '0;
      gi_q        <= '0;
      gap_q       <= '0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      v_q         <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      gi_q        <= gi_d;
      gap_q       <= gap_d;
      i_q         <= i_d;
      j_q         <= j_d;
      k_q         <= k_d;
      v_q         <= v_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
      out_last_q  <= out_last_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_key_o   = out_q[DW-1:dss_pkg::TAG_W];
  assign out_tag_o   = out_q[dss_pkg::TAG_W-1:0];
  assign out_last_o  = out_last_q;

endmodule

// ----- rtl/core/depth_shell_sort.sv -----
// Depth shell sort: loads a list of keyed items, sorts descending, streams them out.
//
// Channels: in_i takes items (sort_key, item_tag, last_item) on valid/ready;
// out_o returns the sorted items (sorted_key, sorted_tag, last_out).
// Loading: one item per cycle while in_i.ready is high. An item with
// last_item set closes the list; items beyond MAX_ITEMS are dropped, but a
// dropped item with last_item still closes the list.
// Sorting: shell sort with gaps 121, 40, 13, 4, 1 (starting below the first
// gap above the count), descending, stable only as the gap sequence allows.
// All work runs over one item store with one write and one registered read
// port and one shared key comparator; each insertion reads its item, then
// compares and shifts the items one gap below while they hold smaller keys,
// then writes the held item into its slot; the gap search walks up the table.
// Emission: each item is read from the store, loaded into the output register
// and held until out_o.ready; last_out marks the final item. A stalled receiver
// holds the output register and the sequencer; in_i.ready stays low from the
// cycle after the last item until the final result is taken.
// Reset: asynchronous, empties the list; no clearing pass of the store.
module depth_shell_sort #(
  parameter int MAX_ITEMS = 64,
  parameter int KEY_WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dss_in_if.sink    in_i,
  dss_out_if.source out_o
);

  localparam int IDX_W = $clog2(MAX_ITEMS);
  localparam int DW    = KEY_WIDTH + dss_pkg::TAG_W;

  dss_pkg::mem_cmd_t mem_cmd;
  logic [IDX_W-1:0]  waddr;
  logic [IDX_W-1:0]  raddr;
  logic [DW-1:0]     wdata;
  logic [DW-1:0]     rdata;

  dss_ctrl #(
    .MAX_ITEMS (MAX_ITEMS),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_key_i    (in_i.sort_key),
    .in_tag_i    (in_i.item_tag),
    .in_last_i   (in_i.last_item),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_key_o   (out_o.sorted_key),
    .out_tag_o   (out_o.sorted_tag),
    .out_last_o  (out_o.last_out),
    .mem_cmd_o   (mem_cmd),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .raddr_o     (raddr),
    .rdata_i     (rdata)
  );

  dss_store #(
    .DEPTH (MAX_ITEMS),
    .DW    (DW)
  ) u_store (
    .clk_i   (clk_i),
    .cmd_i   (mem_cmd),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

endmodule

// ----- rtl/core/dss_check.sv -----
// Port-level checker for the depth shell sort, bound to the top level.
`include "depth_shell_sort_assert.svh"

module dss_check #(
  parameter int KEY_WIDTH = 32
) (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      in_last_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [KEY_WIDTH-1:0]      out_key_i,
  input logic [dss_pkg::TAG_W-1:0] out_tag_i,
  input logic                      out_last_i
);

  // Loading and emitting never overlap
  `DSS_ASSERT_NOW(a_no_load_while_emit, out_valid_i, !in_ready_i, "ready during emission")

  // A stalled result item holds
  `DSS_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i,
    out_valid_i && $stable(out_key_i) && $stable(out_tag_i) && $stable(out_last_i),
    "stalled result changed")

  // Closing item ends loading
  `DSS_ASSERT_NEXT(a_last_closes, in_valid_i && in_ready_i && in_last_i, !in_ready_i,
    "still loading after last item")

  // Final result returns the block to loading
  `DSS_ASSERT_NEXT(a_last_out_done, out_valid_i && out_ready_i && out_last_i,
    in_ready_i && !out_valid_i, "not back to loading after final result")

endmodule

bind depth_shell_sort dss_check #(
  .KEY_WIDTH (KEY_WIDTH)
) u_dss_check (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_last_i   (in_i.last_item),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_key_i   (out_o.sorted_key),
  .out_tag_i   (out_o.sorted_tag),
  .out_last_i  (out_o.last_out)
);

// ----- verif/tb_depth_shell_sort.sv -----
// Testbench for depth_shell_sort: random and directed lists checked against a shell sort predictor.
module tb_depth_shell_sort;

  localparam int KEY_W       = 32;
  localparam int LIST_CAP    = 64;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_WAIT  = 40;

  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

  typedef logic signed [KEY_W-1:0]   depth_key_t;
  typedef logic [dss_pkg::TAG_W-1:0] item_tag_t;

  // How random keys are drawn
  typedef enum int {KEYS_SPREAD, KEYS_CLUSTERED, KEYS_EDGES} key_mix_e;

  // One sorted item as it should leave the block
  typedef struct {
    depth_key_t key;
    item_tag_t  tag;
    logic       last;
  } sorted_item_t;

  logic clk_i;
  logic rst_ni;

  dss_in_if  #(.KEY_WIDTH(KEY_W)) in_if ();
  dss_out_if #(.KEY_WIDTH(KEY_W)) out_if ();

  depth_shell_sort #(
    .MAX_ITEMS(LIST_CAP),
    .KEY_WIDTH(KEY_W)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // Predictor copy of the item store
  depth_key_t   held_key [LIST_CAP];
  item_tag_t    held_tag [LIST_CAP];
  int unsigned  held_count;
  sorted_item_t sorted_due[$];

  // Idling controls and counters
  int send_idle_pct;
  int recv_stall_pct;
  int hold_cycles_req;
  int items_sent;
  int lists_sent;
  int items_checked;
  int mismatch_count;
  int cycles_run;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Descending shell sort over the held items, gaps 3h+1 from above the count
  function automatic void shell_sort_held(input int unsigned n);
    int unsigned gap;
    int unsigned j;
    depth_key_t  vk;
    item_tag_t   vt;
    gap = 1;
    do gap = 3 * gap + 1; while (gap <= n);
    do begin
      gap = gap / 3;
      for (int unsigned i = gap; i < n; i++) begin
        vk = held_key[i];
        vt = held_tag[i];
        j  = i;
        // strict less-than only: equal keys stay put
        while (held_key[j-gap] < vk) begin
          held_key[j] = held_key[j-gap];
          held_tag[j] = held_tag[j-gap];
          j = j - gap;
          if (j < gap) break;
        end
        held_key[j] = vk;
        held_tag[j] = vt;
      end
    end while (gap != 1);
  endfunction

  // Take one accepted item; a closing item queues the whole sorted list
  function automatic void absorb_item(input depth_key_t key, input item_tag_t tag,
                                      input logic last);
    sorted_item_t s;
    if (held_count < LIST_CAP) begin
      held_key[held_count] = key;
      held_tag[held_count] = tag;
      held_count++;
    end
    if (last) begin
      shell_sort_held(held_count);
      for (int unsigned k = 0; k < held_count; k++) begin
        s.key  = held_key[k];
        s.tag  = held_tag[k];
        s.last = (k + 1 == held_count);
        sorted_due.push_back(s);
      end
      held_count = 0;
    end
  endfunction

  function automatic depth_key_t pick_key(input key_mix_e mix);
    depth_key_t k;
    case (mix)
      KEYS_CLUSTERED: k = $signed(KEY_W'($urandom_range(6))) - 3;
      KEYS_EDGES: begin
        case ($urandom_range(4))
          0:       k = KEY_MIN;
          1:       k = KEY_MAX;
          2:       k = '0;
          3:       k = '1;
          default: k = $urandom;
        endcase
      end
      default: k = $urandom;
    endcase
    return k;
  endfunction

  // Mostly very short lists, some up to a dozen items
  function automatic int pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 75) return $urandom_range(1, 4);
    return $urandom_range(5, 12);
  endfunction

  // Send one item, with random idle cycles ahead of it
  task automatic send_item(input depth_key_t key, input item_tag_t tag, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid     <= 1'b0;
      in_if.sort_key  <= $urandom;
      in_if.item_tag  <= item_tag_t'($urandom);
      in_if.last_item <= 1'($urandom);
      @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.sort_key  <= key;
    in_if.item_tag  <= tag;
    in_if.last_item <= last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    absorb_item(key, tag, last);
    items_sent++;
  endtask

  task automatic send_fixed_list(input depth_key_t keys[$], input item_tag_t tags[$]);
    foreach (keys[k]) send_item(keys[k], tags[k], k == keys.size() - 1);
    lists_sent++;
  endtask

  task automatic send_random_list(input int len, input key_mix_e mix);
    for (int k = 0; k < len; k++) send_item(pick_key(mix), item_tag_t'($urandom), k == len - 1);
    lists_sent++;
  endtask

  // Single item, field extremes, ties, reversed and presorted lists
  task automatic test_directed_lists();
    depth_key_t keys[$];
    item_tag_t  tags[$];
    keys = {KEY_MAX};
    tags = {6'd63};
    send_fixed_list(keys, tags);
    keys = {KEY_MIN, KEY_MAX, 32'sd0, -32'sd1, 32'sd1};
    tags = {6'd0, 6'd63, 6'd21, 6'd42, 6'd5};
    send_fixed_list(keys, tags);
    // equal keys reordered only as the gap passes move them
    keys = {32'sd3, 32'sd3, 32'sd9, 32'sd3, 32'sd9, 32'sd3, 32'sd3};
    tags = {6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd6, 6'd7};
    send_fixed_list(keys, tags);
    keys = {-32'sd2, -32'sd1, 32'sd0, 32'sd1, 32'sd2};
    tags = {6'd10, 6'd11, 6'd12, 6'd13, 6'd14};
    send_fixed_list(keys, tags);
    keys = {32'sd100, 32'sd50, -32'sd50, -32'sd100};
    tags = {6'd20, 6'd21, 6'd22, 6'd23};
    send_fixed_list(keys, tags);
  endtask

  // Store filled exactly, then one extra item and the closing item are dropped
  task automatic test_store_full();
    send_random_list(LIST_CAP + 2, KEYS_CLUSTERED);
  endtask

  // Receiver holds off while the next list is offered, so input stalls
  task automatic test_output_holdoff();
    send_random_list(16, KEYS_SPREAD);
    hold_cycles_req = 400;
    send_random_list(8, KEYS_CLUSTERED);
  endtask

  task automatic test_random_lists(input int idle_pct, input int stall_pct, input int budget);
    int sent;
    int len;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < budget) begin
      len = pick_length();
      if (len > budget - sent) len = budget - sent;
      send_random_list(len, key_mix_e'($urandom_range(2)));
      sent += len;
    end
  endtask

  // Receiver: random stalls plus requested long hold-offs
  initial begin
    int stall_left;
    stall_left   = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles_req != 0) begin
        stall_left      = hold_cycles_req;
        hold_cycles_req = 0;
      end
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Compare each taken result with the oldest expected one
  always @(posedge clk_i) begin
    sorted_item_t exp_item;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (sorted_due.size() == 0) begin
        $error("unexpected item: sorted_key %0d sorted_tag %0d last_out %0b",
               out_if.sorted_key, out_if.sorted_tag, out_if.last_out);
        mismatch_count++;
      end else begin
        exp_item = sorted_due.pop_front();
        items_checked++;
        if (out_if.sorted_key !== exp_item.key) begin
          $error("sorted_key: expected %0d, got %0d", exp_item.key, out_if.sorted_key);
          mismatch_count++;
        end
        if (out_if.sorted_tag !== exp_item.tag) begin
          $error("sorted_tag: expected %0d, got %0d", exp_item.tag, out_if.sorted_tag);
          mismatch_count++;
        end
        if (out_if.last_out !== exp_item.last) begin
          $error("last_out: expected %0b, got %0b", exp_item.last, out_if.last_out);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    cycles_run = 0;
    while (cycles_run < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles_run++;
    end
    $display("[depth_shell_sort] ERROR");
    $finish;
  end

  // Test sequence
  initial begin
    held_count      = 0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    hold_cycles_req = 0;
    items_sent      = 0;
    lists_sent      = 0;
    items_checked   = 0;
    mismatch_count  = 0;
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.sort_key  = '0;
    in_if.item_tag  = '0;
    in_if.last_item = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_lists();
    test_store_full();
    test_output_holdoff();
    test_random_lists(0, 0, 12);
    test_random_lists(48, 0, 12);
    test_random_lists(0, 48, 12);
    test_random_lists(23, 23, 12);
    in_if.valid <= 1'b0;

    while (sorted_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Sent %0d lists (%0d items, overflowing ones included) under idle, stall",
             lists_sent, items_sent);
    $display("and long hold-off patterns; %0d sorted items checked in %0d cycles.",
             items_checked, cycles_run);
    if (mismatch_count == 0) begin
      $display("[depth_shell_sort] OK");
    end else begin
      $display("[depth_shell_sort] ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/dss_pkg.sv
rtl/core/dss_if.sv
rtl/core/dss_store.sv
rtl/core/dss_ctrl.sv
rtl/core/depth_shell_sort.sv
rtl/core/dss_check.sv
verif/tb_depth_shell_sort.sv
